/* rtl/core/assert_macros.svh */
// Assertion helpers, clocked on clock; reset held high disables the first form.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define SMF_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`define SMF_ASSERT_NR(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`else

`define SMF_ASSERT(lbl, prop, msg)

`define SMF_ASSERT_NR(lbl, prop, msg)

`endif

`endif

/* rtl/core/smf_pkg.sv */
package smf_pkg;

   localparam int DEPTH        = 32;
   localparam int SAMPLE_WIDTH = 16;

   localparam int SAMPLE_IN_W  = 16;
   localparam int MODE_COUNT_W = 6;

   localparam int STORE_W = (SAMPLE_WIDTH < SAMPLE_IN_W) ? SAMPLE_WIDTH : SAMPLE_IN_W;
   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = $clog2(DEPTH + 1);

   typedef enum logic [4:0] {
      ST_LOAD  = 5'b00001,
      ST_RDI   = 5'b00010,
      ST_CAPI  = 5'b00100,
      ST_SWEEP = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   typedef struct packed {
      logic               we;
      logic [IDX_W-1:0]   waddr;
      logic [STORE_W-1:0] wdata;
      logic               re;
      logic [IDX_W-1:0]   raddr;
   } mem_req_type;

   typedef struct packed {
      logic               done;
      logic [STORE_W-1:0] value;
      logic [CNT_W-1:0]   count;
      logic               overflowed;
   } result_type;

   function automatic logic [MODE_COUNT_W-1:0] sat_count(input logic [CNT_W-1:0] c);
      logic [CNT_W+MODE_COUNT_W-1:0] wide;
      wide = (CNT_W+MODE_COUNT_W)'(c);
      if (wide > (CNT_W+MODE_COUNT_W)'({MODE_COUNT_W{1'b1}})) begin
         return {MODE_COUNT_W{1'b1}};
      end else begin
         return wide[MODE_COUNT_W-1:0];
      end
   endfunction

endpackage

/* rtl/core/smf_req_if.sv */
interface smf_req_if import smf_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_IN_W-1:0] sample;
   logic                          last;

   modport source (output valid, output sample, output last, input ready);
   modport sink   (input valid, input sample, input last, output ready);
endinterface

/* rtl/core/smf_rsp_if.sv */
interface smf_rsp_if import smf_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_IN_W-1:0] mode_value;
   logic [MODE_COUNT_W-1:0]       mode_count;
   logic                          overflowed;

   modport source (output valid, output mode_value, output mode_count, output overflowed,
                   input ready);
   modport sink   (input valid, input mode_value, input mode_count, input overflowed,
                   output ready);
endinterface

/* rtl/core/smf_buffer.sv */
module smf_buffer import smf_pkg::*; (
   input  logic               clock,
   input  mem_req_type        mem_req,
   output logic [STORE_W-1:0] rd_data
);

   logic [STORE_W-1:0] mem_ff [DEPTH];
   logic [STORE_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem_ff[mem_req.waddr] <= mem_req.wdata;
      end
      if (mem_req.re) begin
         rdata_ff <= mem_ff[mem_req.raddr];
      end
   end

   assign rd_data = rdata_ff;

endmodule

/* rtl/core/smf_scan.sv */
`include "assert_macros.svh"

module smf_scan import smf_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [SAMPLE_IN_W-1:0] in_sample,
   input  logic                   in_last,
   output logic                   in_ready,
   input  logic                   rsp_free,
   output mem_req_type            mem_req,
   input  logic [STORE_W-1:0]     mem_rdata,
   output result_type             result
);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic               ovf_ff, ovf_in;
   logic [IDX_W-1:0]   i_ff, i_in;
   logic [CNT_W-1:0]   j_ff, j_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [STORE_W-1:0] cand_ff, cand_in;
   logic [STORE_W-1:0] best_val_ff, best_val_in;
   logic [CNT_W-1:0]   best_cnt_ff, best_cnt_in;
   logic [CNT_W-1:0]   cnt_sum;
   logic               hit;

   assign hit     = (mem_rdata == cand_ff);
   assign cnt_sum = cnt_ff + CNT_W'(hit);

   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      ovf_in      = ovf_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      cnt_in      = cnt_ff;
      cand_in     = cand_ff;
      best_val_in = best_val_ff;
      best_cnt_in = best_cnt_ff;
      mem_req     = '0;
      mem_req.wdata = in_sample[STORE_W-1:0];
      in_ready    = (state_ff == ST_LOAD);
      result.done       = 1'b0;
      result.value      = best_val_ff;
      result.count      = best_cnt_ff;
      result.overflowed = ovf_ff;

      unique case (state_ff)
         ST_LOAD: begin
            if (in_valid) begin
               if (fill_ff < CNT_W'(DEPTH)) begin
                  mem_req.we    = 1'b1;
                  mem_req.waddr = fill_ff[IDX_W-1:0];
                  fill_in       = fill_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (in_last) begin
                  state_in    = ST_RDI;
                  i_in        = '0;
                  best_val_in = '0;
                  best_cnt_in = '0;
               end
            end
         end
         ST_RDI: begin
            mem_req.re    = 1'b1;
            mem_req.raddr = i_ff;
            state_in      = ST_CAPI;
         end
         ST_CAPI: begin
            cand_in       = mem_rdata;
            mem_req.re    = 1'b1;
            mem_req.raddr = '0;
            j_in          = CNT_W'(1);
            cnt_in        = '0;
            state_in      = ST_SWEEP;
         end
         ST_SWEEP: begin
            cnt_in = cnt_sum;
            if (j_ff == fill_ff) begin
               if (cnt_sum > best_cnt_ff) begin
                  best_cnt_in = cnt_sum;
                  best_val_in = cand_ff;
               end
               if (CNT_W'(i_ff) + CNT_W'(1) == fill_ff) begin
                  state_in = ST_DONE;
               end else begin
                  i_in     = i_ff + IDX_W'(1);
                  state_in = ST_RDI;
               end
            end else begin
               mem_req.re    = 1'b1;
               mem_req.raddr = j_ff[IDX_W-1:0];
               j_in          = j_ff + CNT_W'(1);
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               result.done = 1'b1;
               fill_in     = '0;
               ovf_in      = 1'b0;
               state_in    = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         fill_ff     <= '0;
         ovf_ff      <= 1'b0;
         i_ff        <= '0;
         j_ff        <= '0;
         cnt_ff      <= '0;
         best_val_ff <= '0;
         best_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         ovf_ff      <= ovf_in;
         i_ff        <= i_in;
         j_ff        <= j_in;
         cnt_ff      <= cnt_in;
         best_val_ff <= best_val_in;
         best_cnt_ff <= best_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff <= cand_in;
   end

   `SMF_ASSERT(a_ovf_needs_full, ovf_ff |-> (fill_ff == CNT_W'(DEPTH)), "overflow with room left")
   `SMF_ASSERT(a_last_starts_scan, (state_ff == ST_LOAD && in_valid && in_last) |=> (state_ff == ST_RDI && fill_ff != '0), "last word did not start scan")
   `SMF_ASSERT(a_sweep_bounds, (state_ff == ST_SWEEP) |-> (j_ff != '0 && j_ff <= fill_ff && CNT_W'(i_ff) < fill_ff), "sweep index out of range")

endmodule

/* rtl/core/sample_mode_finder.sv */
// channel | dir | word                           | handshake
// req_bus | in  | sample[15:0] signed, last      | valid/ready
// rsp_bus | out | mode_value[15:0], mode_count[5:0], overflowed | valid/ready
//
// Loading: one cycle per sample word; req_bus.ready is high while loading.
// On the last word, n stored samples are compared pairwise through the single
// buffer read port; no input is taken meanwhile.
// The result sits in an output register; loading of the next batch goes on while it waits.
// Synchronous reset empties the batch; buffer contents are not cleared.
`include "assert_macros.svh"

module sample_mode_finder import smf_pkg::*; (
   input logic       clock,
   input logic       reset,
   smf_req_if.sink   req_bus,
   smf_rsp_if.source rsp_bus
);

   mem_req_type             mem_req;
   logic [STORE_W-1:0]      mem_rdata;
   result_type              result;
   logic                    rsp_free;
   logic                    rsp_valid_ff;
   logic [SAMPLE_IN_W-1:0]  rsp_value_ff;
   logic [MODE_COUNT_W-1:0] rsp_count_ff;
   logic                    rsp_ovf_ff;

   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;

   smf_buffer u_buffer (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (mem_rdata)
   );

   smf_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_sample (req_bus.sample),
      .in_last   (req_bus.last),
      .in_ready  (req_bus.ready),
      .rsp_free  (rsp_free),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (result.done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (result.done) begin
         rsp_value_ff <= SAMPLE_IN_W'(result.value);
         rsp_count_ff <= sat_count(result.count);
         rsp_ovf_ff   <= result.overflowed;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.mode_value = rsp_value_ff;
   assign rsp_bus.mode_count = rsp_count_ff;
   assign rsp_bus.overflowed = rsp_ovf_ff;

   `SMF_ASSERT(a_done_slot_free, result.done |-> rsp_free, "result dropped over a waiting word")
   `SMF_ASSERT(a_count_nonzero, result.done |=> (rsp_valid_ff && rsp_count_ff != '0), "empty mode count")
   `SMF_ASSERT_NR(a_reset_clears, reset |=> !rsp_valid_ff, "response valid after reset")

endmodule
